// ----- rtl/tvps_pkg.sv -----
// Package: shared constants, types and codes of the timed valve pulse scheduler.
package tvps_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF  = 64;

  localparam logic [8:0]  CH_COUNT_RESET = 9'd136;
  localparam logic [19:0] NS_PER_MS      = 20'd1000000;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned ENTRY_W    = 89;

  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_WORD   = 1'b1;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_ARM    = 2'd2,
    KIND_DISARM = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_ARM,
    S_DIS,
    S_STAT,
    S_QRD,
    S_QEV,
    S_SUM,
    S_CWR,
    S_ERD,
    S_ECMP,
    S_EOUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic cmd_exec;
    logic arm_exec;
    logic dis_exec;
    logic out_status;
    logic q_keep;
    logic q_take;
    logic q_sum;
    logic q_write;
    logic q_finish;
    logic e_bit;
    logic e_next;
    logic out_word;
    logic ch_phase;
  } cmd_t;

  typedef struct packed {
    logic q_done;
    logic due;
    logic word_end;
    logic last_word;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/timed_valve_pulse_scheduler.sv -----
// Top level of the timed valve pulse scheduler.
// Items are taken one at a time. A command or an arm executes, then waits
// for a free result register to give its status result. A tick walks the
// pending queue, keeping or firing each entry, then scans the channel store
// one channel at a time, through the unpipelined registered read of the
// off-time store, and emits each 64-channel word (up to 4 words) once the
// result register is free. A disarm clears the queue and channel state,
// then scans the same way.
// The result register lets a new item in while the last result waits.
// Channel state comes out of reset cleared at once; no clearing pass.
module timed_valve_pulse_scheduler #(
  parameter int unsigned MAX_CHANNELS = tvps_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH  = tvps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // nozzle_id[8:0], fire_time[72:9], duration_ms[88:73], now_time[152:89]
  input  logic [tvps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // valve_word[63:0], word_index[65:64], cmd_accepted[66], is_armed[67],
  // accepted_total[99:68], rejected_total[131:100]
  output logic [tvps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // result_kind[0]
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [8:0]                        cfg_data_i
);
  tvps_pkg::cmd_t cmd;
  tvps_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tvps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tvps_dp #(.MAX_CHANNELS(MAX_CHANNELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast)
  );

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0] == tvps_pkg::RES_STATUS) |-> m_axis_tlast)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0] == tvps_pkg::RES_STATUS)
      |-> (m_axis_tdata[65:0] == 66'd0))
    else $error("status result carries bitmap data");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in progress");
endmodule

// ----- rtl/tvps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tvps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/tvps_ctrl.sv -----
// Controller: sequences command, arm, disarm and tick processing.
module tvps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_kind_i,
  output logic           in_ready_o,
  input  tvps_pkg::sts_t sts_i,
  output tvps_pkg::cmd_t cmd_o
);
  tvps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tvps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tvps_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (tvps_pkg::kind_e'(in_kind_i))
            tvps_pkg::KIND_CMD:  state_d = tvps_pkg::S_CMD;
            tvps_pkg::KIND_TICK: state_d = tvps_pkg::S_QRD;
            tvps_pkg::KIND_ARM:  state_d = tvps_pkg::S_ARM;
            default:             state_d = tvps_pkg::S_DIS;
          endcase
        end
      end
      tvps_pkg::S_CMD: begin
        cmd_o.cmd_exec = 1'b1;
        state_d        = tvps_pkg::S_STAT;
      end
      tvps_pkg::S_ARM: begin
        cmd_o.arm_exec = 1'b1;
        state_d        = tvps_pkg::S_STAT;
      end
      tvps_pkg::S_DIS: begin
        cmd_o.dis_exec = 1'b1;
        state_d        = tvps_pkg::S_ERD;
      end
      tvps_pkg::S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.out_status = 1'b1;
          state_d          = tvps_pkg::S_IDLE;
        end
      end
      tvps_pkg::S_QRD: begin
        if (sts_i.q_done) begin
          cmd_o.q_finish = 1'b1;
          state_d        = tvps_pkg::S_ERD;
        end else begin
          state_d = tvps_pkg::S_QEV;
        end
      end
      tvps_pkg::S_QEV: begin
        if (sts_i.due) begin
          cmd_o.q_take = 1'b1;
          state_d      = tvps_pkg::S_SUM;
        end else begin
          cmd_o.q_keep = 1'b1;
          state_d      = tvps_pkg::S_QRD;
        end
      end
      tvps_pkg::S_SUM: begin
        cmd_o.q_sum = 1'b1;
        state_d     = tvps_pkg::S_CWR;
      end
      tvps_pkg::S_CWR: begin
        cmd_o.q_write = 1'b1;
        state_d       = tvps_pkg::S_QRD;
      end
      tvps_pkg::S_ERD: begin
        cmd_o.ch_phase = 1'b1;
        state_d        = tvps_pkg::S_ECMP;
      end
      tvps_pkg::S_ECMP: begin
        cmd_o.ch_phase = 1'b1;
        cmd_o.e_bit    = 1'b1;
        if (sts_i.word_end) begin
          state_d = tvps_pkg::S_EOUT;
        end else begin
          cmd_o.e_next = 1'b1;
          state_d      = tvps_pkg::S_ERD;
        end
      end
      tvps_pkg::S_EOUT: begin
        cmd_o.ch_phase = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_word = 1'b1;
          if (sts_i.last_word) begin
            state_d = tvps_pkg::S_IDLE;
          end else begin
            cmd_o.e_next = 1'b1;
            state_d      = tvps_pkg::S_ERD;
          end
        end
      end
      default: state_d = tvps_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- rtl/tvps_dp.sv -----
// Datapath: pending queue, channel off-time store, counters and result register.
module tvps_dp #(
  parameter int unsigned MAX_CHANNELS = tvps_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH  = tvps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tvps_pkg::cmd_t                      cmd_i,
  output tvps_pkg::sts_t                      sts_o,
  input  logic [tvps_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [8:0]                          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tvps_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_kind_o,
  output logic                                out_last_o
);
  localparam int unsigned QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAP = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
  localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned EW  = tvps_pkg::ENTRY_W;

  logic [8:0]  count_q;
  logic        armed_q;
  logic [31:0] acc_cnt_q, rej_cnt_q;
  logic [CW-1:0] cnt_q, i_q, keep_q;
  logic [CAP-1:0] vld_q;
  logic        zero_q, acc_flag_q;

  logic [8:0]  nz_q;
  logic [63:0] fire_q, now_q;
  logic [15:0] dur_q;

  logic [8:0]  tnz_q;
  logic [35:0] prod_q;
  logic [63:0] off_q;
  logic [7:0]  ch_q;
  logic [63:0] word_q;

  logic          out_vld_q, out_kind_q, out_last_q;
  logic [63:0]   out_word_q;
  logic [1:0]    out_idx_q;
  logic          out_acc_q, out_armed_q;
  logic [31:0]   out_acct_q, out_rejt_q;

  logic [8:0]    n_act;
  logic [1:0]    wl;
  logic          ok;
  logic          q_we;
  logic [QW-1:0] q_waddr;
  logic [EW-1:0] q_wdata, q_rdata;
  logic [8:0]    e_nz;
  logic [63:0]   e_fire;
  logic [15:0]   e_dur;
  logic [AW-1:0] tidx, eidx, ch_raddr;
  logic [63:0]   ch_rdata, cur;
  logic          ch_we;
  logic [64:0]   sum;
  logic          out_free;

  assign n_act = (count_q > 9'(CAP)) ? 9'(CAP) : count_q;
  assign wl    = (n_act == 9'd0) ? 2'd0 : 2'((n_act - 9'd1) >> 6);
  assign ok    = armed_q && (nz_q != 9'd0) && (nz_q <= n_act) && (cnt_q < CW'(QUEUE_DEPTH));

  assign e_nz   = q_rdata[8:0];
  assign e_fire = q_rdata[72:9];
  assign e_dur  = q_rdata[88:73];

  assign q_we    = (cmd_i.cmd_exec && ok) || cmd_i.q_keep;
  assign q_waddr = cmd_i.q_keep ? keep_q[QW-1:0] : cnt_q[QW-1:0];
  assign q_wdata = cmd_i.q_keep ? q_rdata : {dur_q, fire_q, nz_q};

  tvps_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (i_q[QW-1:0]),
    .rdata_o (q_rdata)
  );

  assign tidx     = AW'(tnz_q - 9'd1);
  assign eidx     = AW'(ch_q);
  assign ch_raddr = cmd_i.ch_phase ? eidx : tidx;
  assign cur      = vld_q[tidx] ? ch_rdata : 64'd0;
  assign ch_we    = cmd_i.q_write && (off_q > cur);
  assign sum      = {1'b0, now_q} + {29'd0, prod_q};

  tvps_ram #(.WIDTH(64), .DEPTH(CAP)) u_chan (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (tidx),
    .wdata_i (off_q),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  assign out_free       = !out_vld_q || out_ready_i;
  assign sts_o.q_done    = (i_q == cnt_q);
  assign sts_o.due       = (e_fire <= now_q);
  assign sts_o.word_end  = &ch_q[5:0];
  assign sts_o.last_word = (ch_q[7:6] == wl);
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= tvps_pkg::CH_COUNT_RESET;
      armed_q   <= 1'b0;
      acc_cnt_q <= 32'd0;
      rej_cnt_q <= 32'd0;
      cnt_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.cmd_exec) begin
        if (ok) begin
          cnt_q <= cnt_q + CW'(1);
          if (acc_cnt_q != 32'hFFFF_FFFF) acc_cnt_q <= acc_cnt_q + 32'd1;
        end else begin
          if (rej_cnt_q != 32'hFFFF_FFFF) rej_cnt_q <= rej_cnt_q + 32'd1;
        end
      end
      if (cmd_i.arm_exec) begin
        armed_q <= 1'b1;
      end
      if (cmd_i.dis_exec) begin
        armed_q <= 1'b0;
        cnt_q   <= '0;
        vld_q   <= '0;
      end
      if (cmd_i.q_finish) begin
        cnt_q <= keep_q;
      end
      if (ch_we) begin
        vld_q[tidx] <= 1'b1;
      end
      if (cmd_i.out_status || cmd_i.out_word) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      nz_q   <= in_data_i[8:0];
      fire_q <= in_data_i[72:9];
      dur_q  <= in_data_i[88:73];
      now_q  <= in_data_i[152:89];
      i_q    <= '0;
      keep_q <= '0;
      ch_q   <= 8'd0;
      word_q <= 64'd0;
      zero_q <= 1'b0;
      acc_flag_q <= 1'b0;
    end
    if (cmd_i.cmd_exec) begin
      acc_flag_q <= ok;
    end
    if (cmd_i.dis_exec) begin
      zero_q <= 1'b1;
    end
    if (cmd_i.q_keep) begin
      keep_q <= keep_q + CW'(1);
      i_q    <= i_q + CW'(1);
    end
    if (cmd_i.q_take) begin
      tnz_q  <= e_nz;
      prod_q <= {20'd0, e_dur} * {16'd0, tvps_pkg::NS_PER_MS};
    end
    if (cmd_i.q_sum) begin
      off_q <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    end
    if (cmd_i.q_write) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.e_bit && ({1'b0, ch_q} < n_act) && !zero_q && vld_q[eidx]
        && (ch_rdata > now_q)) begin
      word_q[ch_q[5:0]] <= 1'b1;
    end
    if (cmd_i.e_next) begin
      ch_q <= ch_q + 8'd1;
    end
    if (cmd_i.out_status) begin
      out_kind_q  <= tvps_pkg::RES_STATUS;
      out_word_q  <= 64'd0;
      out_idx_q   <= 2'd0;
      out_last_q  <= 1'b1;
      out_acc_q   <= acc_flag_q;
      out_armed_q <= armed_q;
      out_acct_q  <= acc_cnt_q;
      out_rejt_q  <= rej_cnt_q;
    end
    if (cmd_i.out_word) begin
      out_kind_q  <= tvps_pkg::RES_WORD;
      out_word_q  <= word_q;
      out_idx_q   <= ch_q[7:6];
      out_last_q  <= sts_o.last_word;
      out_acc_q   <= 1'b0;
      out_armed_q <= armed_q;
      out_acct_q  <= acc_cnt_q;
      out_rejt_q  <= rej_cnt_q;
      word_q      <= 64'd0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {4'd0, out_rejt_q, out_acct_q, out_armed_q, out_acc_q,
                        out_idx_q, out_word_q};
endmodule
